>>> rtl/core/spmc_pkg.sv
// Shared types and constants for the solar pump mode controller.
`default_nettype none
package spmc_pkg;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_STAB   = 2'd1,
    MODE_ACTIVE = 2'd2,
    MODE_HIBER  = 2'd3
  } mode_t;

  // register indexes on the configuration port
  localparam logic [2:0] REG_INLET_LIMIT   = 3'd0;
  localparam logic [2:0] REG_ENERGY_THRESH = 3'd1;
  localparam logic [2:0] REG_STAB_DELAY    = 3'd2;
  localparam logic [2:0] REG_TRIG_DELAY    = 3'd3;
  localparam logic [2:0] REG_HIBER_PERIOD  = 3'd4;

  localparam int unsigned MUL_A_W = 24;
  localparam int unsigned MUL_B_W = 25;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // 4180/15360 reduces to 209/768; 768 = 256 * 3
  localparam logic [MUL_B_W-1:0] GAIN_NUM   = 25'd209;
  // ceil(2^26 / 3): exact quotient for dividends below 2^25
  localparam logic [MUL_B_W-1:0] RECIP3     = 25'd22369622;
  localparam int unsigned        RECIP3_SH  = 26;

  localparam logic [22:0] GAIN_MAX_MAG = 23'd4194303;
  localparam logic [22:0] GAIN_MIN_MAG = 23'd4194304;
  localparam logic [31:0] POOL_AGE_MS  = 32'd3600000;

  typedef struct packed {
    logic signed [11:0] inlet_limit;
    logic [21:0]        energy_threshold_w;
    logic [31:0]        stability_delay_ms;
    logic [31:0]        trigger_delay_ms;
    logic [31:0]        hibernation_period_ms;
  } spmc_cfg_t;

endpackage
`default_nettype wire

>>> rtl/core/solar_pump_mode_controller_core.sv
// Top level: sequencer, mode state machine and output register of the pump controller.
//
//  channel | direction | transfer when                     | payload
//  in_*    | sink      | in_tvalid & in_tready             | time, inlet, outlet, flow
//  out_*   | source    | out_tvalid & out_tready           | pump, mode, gain, pool record
//  cfg_*   | APB slave | psel & penable & pwrite & pready  | five control registers
//
// Each item goes through the accept step, three passes through the shared
// 24x25 multiplier (magnitude, scale by 209, divide by 768) and an update step.
// in_tready is high only while the sequencer is idle.
// The update cycle holds while a previous result is still waiting on out_tready.
// rst_n is synchronous; it clears the mode, pump and timer state and the registers.
`default_nettype none
module solar_pump_mode_controller_core
  import spmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [31:0] now_ms, [43:32] inlet_temp, [55:44] outlet_temp, [67:56] flow_rate
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] pump_on, [2:1] mode, [25:3] heat_gain_w, [37:26] pool_temp,
  // [69:38] pool_temp_time
  output logic [71:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_SCALE,
    ST_DIV,
    ST_UPD
  } state_t;

  spmc_cfg_t cfg;

  spmc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  logic               pump_r, pump_nxt;
  logic [31:0]        stab_start_r, stab_start_nxt;
  logic [31:0]        hib_start_r, hib_start_nxt;
  logic [31:0]        gain_ok_r, gain_ok_nxt;
  logic signed [11:0] pool_temp_r, pool_temp_nxt;
  logic [31:0]        pool_time_r, pool_time_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [71:0]        out_data_r, out_data_nxt;

  // latched item
  logic [31:0]        now_r, now_nxt;
  logic signed [11:0] tin_r, tin_nxt;
  logic [11:0]        flow_r, flow_nxt;
  logic [11:0]        dmag_r, dmag_nxt;
  logic               neg_r, neg_nxt;

  logic               in_hs;
  logic signed [12:0] diff;
  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic [22:0]        qmag;
  logic signed [22:0] gain;
  logic               gain_ok;
  logic               out_free;

  spmc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_hs      = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign diff = 13'(signed'(in_tdata[55:44])) - 13'(signed'(in_tdata[43:32]));

  // route operands of the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      ST_MAG: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(flow_r);
        mul_b  = MUL_B_W'(dmag_r);
      end
      ST_SCALE: begin
        mul_en = 1'b1;
        mul_a  = mul_p[MUL_A_W-1:0];
        mul_b  = GAIN_NUM;
      end
      ST_DIV: begin
        mul_en = 1'b1;
        mul_a  = mul_p[MUL_A_W+7:8];
        mul_b  = RECIP3;
      end
      default: ;
    endcase
  end

  // saturate the magnitude and apply the sign (truncation toward zero)
  assign qmag = mul_p[RECIP3_SH+22:RECIP3_SH];
  always_comb begin
    if (neg_r) begin
      gain = (qmag > GAIN_MIN_MAG) ? 23'sh400000 : 23'(-signed'({1'b0, qmag}));
    end else begin
      gain = (qmag > GAIN_MAX_MAG) ? 23'(GAIN_MAX_MAG) : signed'(qmag);
    end
  end
  assign gain_ok = (24'(gain) >= signed'({2'b00, cfg.energy_threshold_w}));

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    pump_nxt       = pump_r;
    stab_start_nxt = stab_start_r;
    hib_start_nxt  = hib_start_r;
    gain_ok_nxt    = gain_ok_r;
    pool_temp_nxt  = pool_temp_r;
    pool_time_nxt  = pool_time_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    now_nxt        = now_r;
    tin_nxt        = tin_r;
    flow_nxt       = flow_r;
    dmag_nxt       = dmag_r;
    neg_nxt        = neg_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_hs) begin
          now_nxt   = in_tdata[31:0];
          tin_nxt   = in_tdata[43:32];
          flow_nxt  = in_tdata[67:56];
          neg_nxt   = diff[12];
          dmag_nxt  = diff[12] ? 12'(-diff) : diff[11:0];
          state_nxt = ST_MAG;
        end
      end
      ST_MAG:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_UPD;
      ST_UPD: begin
        // hold until the output register is free
        if (out_free) begin
          unique case (mode_r)
            MODE_INIT: begin
              stab_start_nxt = now_r;
              hib_start_nxt  = now_r;
              gain_ok_nxt    = now_r - cfg.trigger_delay_ms;
              pump_nxt       = 1'b1;
              mode_nxt       = MODE_STAB;
            end
            MODE_STAB: begin
              pool_time_nxt = now_r - POOL_AGE_MS;
              if ((now_r - stab_start_r) > cfg.stability_delay_ms) begin
                mode_nxt = MODE_ACTIVE;
              end
            end
            MODE_ACTIVE: begin
              pool_temp_nxt = tin_r;
              pool_time_nxt = now_r;
              if ((tin_r > cfg.inlet_limit) ||
                  (!gain_ok && ((now_r - gain_ok_r) > cfg.trigger_delay_ms))) begin
                mode_nxt      = MODE_HIBER;
                pump_nxt      = 1'b0;
                hib_start_nxt = now_r;
              end else if (gain_ok) begin
                gain_ok_nxt = now_r;
              end
            end
            MODE_HIBER: begin
              if ((now_r - hib_start_r) > cfg.hibernation_period_ms) begin
                stab_start_nxt = now_r;
                pump_nxt       = 1'b1;
                mode_nxt       = MODE_STAB;
              end
            end
            default: ;
          endcase
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, pool_time_nxt, pool_temp_nxt, gain, mode_nxt, pump_nxt};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_INIT;
      pump_r       <= 1'b0;
      stab_start_r <= '0;
      hib_start_r  <= '0;
      gain_ok_r    <= '0;
      pool_temp_r  <= '0;
      pool_time_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      pump_r       <= pump_nxt;
      stab_start_r <= stab_start_nxt;
      hib_start_r  <= hib_start_nxt;
      gain_ok_r    <= gain_ok_nxt;
      pool_temp_r  <= pool_temp_nxt;
      pool_time_r  <= pool_time_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    now_r      <= now_nxt;
    tin_r      <= tin_nxt;
    flow_r     <= flow_nxt;
    dmag_r     <= dmag_nxt;
    neg_r      <= neg_nxt;
  end

  // pump runs exactly in stabilizing and active
  a_pump_mode: assert property (@(posedge clk) disable iff (!rst_n)
    pump_r == ((mode_r == MODE_STAB) || (mode_r == MODE_ACTIVE)))
    else $error("pump drive disagrees with mode");

  // initializing is left once and never re-entered
  a_no_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_INIT) |=> (mode_r != MODE_INIT))
    else $error("mode returned to initializing");

  // an accepted transaction keeps the sequencer busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_hs |=> !in_tready)
    else $error("input ready right after accept");

  // a result appears only from the update step
  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> ($past(state_r) == ST_UPD))
    else $error("result without update step");

endmodule
`default_nettype wire

>>> rtl/core/spmc_cfg_regs.sv
// APB-style configuration register file for the pump controller.
`default_nettype none
module spmc_cfg_regs
  import spmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output spmc_cfg_t        cfg
);

  spmc_cfg_t  cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inlet_limit           <= 12'sd480;
      cfg_r.energy_threshold_w    <= 22'd200;
      cfg_r.stability_delay_ms    <= 32'd60000;
      cfg_r.trigger_delay_ms      <= 32'd300000;
      cfg_r.hibernation_period_ms <= 32'd1800000;
    end else if (wr_en) begin
      unique case (idx)
        REG_INLET_LIMIT:   cfg_r.inlet_limit           <= pwdata[11:0];
        REG_ENERGY_THRESH: cfg_r.energy_threshold_w    <= pwdata[21:0];
        REG_STAB_DELAY:    cfg_r.stability_delay_ms    <= pwdata;
        REG_TRIG_DELAY:    cfg_r.trigger_delay_ms      <= pwdata;
        REG_HIBER_PERIOD:  cfg_r.hibernation_period_ms <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INLET_LIMIT:   prdata = {{20{cfg_r.inlet_limit[11]}}, cfg_r.inlet_limit};
      REG_ENERGY_THRESH: prdata = {10'd0, cfg_r.energy_threshold_w};
      REG_STAB_DELAY:    prdata = cfg_r.stability_delay_ms;
      REG_TRIG_DELAY:    prdata = cfg_r.trigger_delay_ms;
      REG_HIBER_PERIOD:  prdata = cfg_r.hibernation_period_ms;
      default:           prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/spmc_mul.sv
// Shared registered unsigned multiplier used for the magnitude, scale and divide steps of the gain math.
`default_nettype none
module spmc_mul
  import spmc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0]      p
);

  logic [MUL_P_W-1:0] p_r;

  assign p = p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule
`default_nettype wire
